// ----- rtl/core/mcal_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcal_pkg
// Types, codes and constants for the magnetometer calibration and heading unit.
// ----------------------------------------------------------------------------
package mcal_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int SETTLE_WIDTH  = 16;
  localparam int HEADING_WIDTH = 9;
  localparam int MODE_WIDTH    = 2;

  localparam logic [MODE_WIDTH-1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_TICK    = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_RESTART = 2'd2;

  localparam logic [SETTLE_WIDTH-1:0] SETTLE_RESET = 16'd5000;
  localparam logic [SETTLE_WIDTH-1:0] QUIET_MAX    = 16'hFFFF;

  // cordic datapath
  localparam int FRAC_BITS  = 24;
  localparam int CORDIC_W   = SAMPLE_WIDTH + FRAC_BITS + 4;
  localparam int ANGLE_W    = 27;
  localparam int DEG_SHIFT  = 16;
  localparam int DEG_W      = ANGLE_W - DEG_SHIFT;
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = 5;

  localparam logic signed [ANGLE_W-1:0] DEG_90  = 27'sd5898240;
  localparam logic signed [ANGLE_W-1:0] DEG_180 = 27'sd11796480;
  localparam logic signed [DEG_W-1:0]   FULL_TURN   = 11'sd360;
  localparam logic signed [DEG_W-1:0]   HEADING_MAX = 11'sd359;

  typedef struct packed {
    logic [MODE_WIDTH-1:0]          mode;
    logic signed [SAMPLE_WIDTH-1:0] x_value;
    logic signed [SAMPLE_WIDTH-1:0] y_value;
    logic signed [SAMPLE_WIDTH-1:0] z_value;
  } in_t;

  typedef struct packed {
    logic                           calibrated;
    logic                           finished_now;
    logic                           heading_valid;
    logic [HEADING_WIDTH-1:0]       heading_deg;
    logic signed [SAMPLE_WIDTH-1:0] x_low;
    logic signed [SAMPLE_WIDTH-1:0] x_high;
    logic signed [SAMPLE_WIDTH-1:0] y_low;
    logic signed [SAMPLE_WIDTH-1:0] y_high;
    logic signed [SAMPLE_WIDTH-1:0] z_low;
    logic signed [SAMPLE_WIDTH-1:0] z_high;
  } out_t;

  // arctan(2^-i) in degrees, q16
  function automatic logic signed [ANGLE_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANGLE_W-1:0] val;
    case (idx)
      5'd0:    val = 27'sd2949120;
      5'd1:    val = 27'sd1740967;
      5'd2:    val = 27'sd919879;
      5'd3:    val = 27'sd466945;
      5'd4:    val = 27'sd234379;
      5'd5:    val = 27'sd117304;
      5'd6:    val = 27'sd58666;
      5'd7:    val = 27'sd29335;
      5'd8:    val = 27'sd14668;
      5'd9:    val = 27'sd7334;
      5'd10:   val = 27'sd3667;
      5'd11:   val = 27'sd1833;
      5'd12:   val = 27'sd917;
      5'd13:   val = 27'sd458;
      5'd14:   val = 27'sd229;
      5'd15:   val = 27'sd115;
      5'd16:   val = 27'sd57;
      5'd17:   val = 27'sd29;
      5'd18:   val = 27'sd14;
      5'd19:   val = 27'sd7;
      5'd20:   val = 27'sd4;
      5'd21:   val = 27'sd2;
      5'd22:   val = 27'sd1;
      default: val = 27'sd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mcal_cordic.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcal_cordic
// Iterative vectoring cordic: one rotation step per cycle, then heading in
// whole degrees (angle plus 90, truncated, wrapped into 0..359).
// ----------------------------------------------------------------------------
module mcal_cordic import mcal_pkg::*; #(
  parameter int ITERATIONS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [SAMPLE_WIDTH-1:0] x_in,
  input  logic signed [SAMPLE_WIDTH-1:0] y_in,
  output logic                           done,
  output logic [HEADING_WIDTH-1:0]       heading
);

  localparam int ITER_W = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_ITER  = 2'd1;
  localparam logic [1:0] C_FINAL = 2'd2;

  logic [1:0]                state;
  logic [ITER_W-1:0]         iter;
  logic signed [CORDIC_W-1:0] x_acc;
  logic signed [CORDIC_W-1:0] y_acc;
  logic signed [ANGLE_W-1:0]  z_acc;

  logic signed [CORDIC_W-1:0] x_sc;
  logic signed [CORDIC_W-1:0] y_sc;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [ANGLE_W-1:0]  step_angle;

  logic signed [ANGLE_W-1:0]  angle_sum;
  logic signed [ANGLE_W-1:0]  angle_neg;
  logic signed [DEG_W-1:0]    deg_trunc;
  logic signed [DEG_W-1:0]    deg_wrap;
  logic [HEADING_WIDTH-1:0]   heading_next;

  assign x_sc = {{(CORDIC_W-SAMPLE_WIDTH-FRAC_BITS){x_in[SAMPLE_WIDTH-1]}}, x_in,
                 {FRAC_BITS{1'b0}}};
  assign y_sc = {{(CORDIC_W-SAMPLE_WIDTH-FRAC_BITS){y_in[SAMPLE_WIDTH-1]}}, y_in,
                 {FRAC_BITS{1'b0}}};

  assign dx         = y_acc >>> iter;
  assign dy         = x_acc >>> iter;
  assign step_angle = atan_q16(ATAN_IDX_W'(iter));

  // truncate toward zero, then wrap negatives
  always_comb begin
    angle_sum = DEG_90 + z_acc;
    angle_neg = -angle_sum;
    if (!angle_sum[ANGLE_W-1]) begin
      deg_trunc = angle_sum[ANGLE_W-1:DEG_SHIFT];
    end else begin
      deg_trunc = -$signed(angle_neg[ANGLE_W-1:DEG_SHIFT]);
    end
    deg_wrap = deg_trunc[DEG_W-1] ? (deg_trunc + FULL_TURN) : deg_trunc;
    if (deg_wrap[DEG_W-1]) begin
      heading_next = '0;
    end else if (deg_wrap > HEADING_MAX) begin
      heading_next = HEADING_MAX[HEADING_WIDTH-1:0];
    end else begin
      heading_next = deg_wrap[HEADING_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            iter <= '0;
            if (y_in == '0) begin
              z_acc <= x_in[SAMPLE_WIDTH-1] ? DEG_180 : '0;
              state <= C_FINAL;
            end else if (x_in == '0) begin
              z_acc <= y_in[SAMPLE_WIDTH-1] ? -DEG_90 : DEG_90;
              state <= C_FINAL;
            end else if (x_in[SAMPLE_WIDTH-1]) begin
              x_acc <= -x_sc;
              y_acc <= -y_sc;
              z_acc <= y_in[SAMPLE_WIDTH-1] ? -DEG_180 : DEG_180;
              state <= C_ITER;
            end else begin
              x_acc <= x_sc;
              y_acc <= y_sc;
              z_acc <= '0;
              state <= C_ITER;
            end
          end
        end
        C_ITER: begin
          if (!y_acc[CORDIC_W-1] && (y_acc != '0)) begin
            x_acc <= x_acc + dx;
            y_acc <= y_acc - dy;
            z_acc <= z_acc + step_angle;
          end else if (y_acc[CORDIC_W-1]) begin
            x_acc <= x_acc - dx;
            y_acc <= y_acc + dy;
            z_acc <= z_acc - step_angle;
          end
          iter <= iter + 1'b1;
          if (iter == ITER_W'(ITERATIONS - 1)) begin
            state <= C_FINAL;
          end
        end
        C_FINAL: begin
          heading <= heading_next;
          done    <= 1'b1;
          state   <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/magnetometer_calibration_and_heading_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_calibration_and_heading_unit
// Min/max calibration of X, Y, Z magnetometer samples with a quiet-time
// settle check, then a cordic compass heading for each later sample.
// ----------------------------------------------------------------------------
//   channel  | signals                        | beat
//   ---------+--------------------------------+-------------------------------
//   input    | in_valid, in_ready, in_data    | sample, ms tick or restart
//   output   | out_valid, out_ready, out_data | status, heading and bounds
//   config   | cfg_we, cfg_data               | settle_ms write
//
// ticks, restarts and samples during calibration: result registered in the cycle after accept
// samples after calibration: heading from the cordic loop, one rotation step per
//   cycle; zero and axis vectors skip the loop; result waits for a free output slot
// in_ready is low while a heading is in progress or a result is held
// rst is synchronous; settle_ms returns to 5000, bounds and counters to zero
// ----------------------------------------------------------------------------
module magnetometer_calibration_and_heading_unit import mcal_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [SETTLE_WIDTH-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_t                     in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_t                    out_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_BUSY   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                 state;
  logic [SETTLE_WIDTH-1:0]    settle_ms;
  logic [SETTLE_WIDTH-1:0]    quiet_count;
  logic                       done_flag;
  logic signed [SAMPLE_WIDTH-1:0] x_low, x_high, y_low, y_high, z_low, z_high;

  logic [SETTLE_WIDTH-1:0]    quiet_next;
  logic                       done_next;
  logic                       finished;
  logic                       widened;
  logic signed [SAMPLE_WIDTH-1:0] x_low_next, x_high_next, y_low_next, y_high_next;
  logic signed [SAMPLE_WIDTH-1:0] z_low_next, z_high_next;

  logic                       slot_free;
  logic                       accept;
  logic                       heading_item;
  logic                       out_load;
  logic                       cordic_done;
  logic [HEADING_WIDTH-1:0]   cordic_heading;
  out_t                       item_result;
  out_t                       heading_result;

  assign slot_free    = !out_valid || out_ready;
  assign in_ready     = (state == ST_IDLE) && slot_free;
  assign accept       = in_valid && in_ready;
  assign heading_item = (in_data.mode == MODE_SAMPLE) && done_flag;
  assign out_load     = ((state == ST_IDLE) && accept && !heading_item) ||
                        ((state == ST_FINISH) && slot_free);

  mcal_cordic #(
    .ITERATIONS (ANGLE_ITERATIONS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && heading_item),
    .x_in    (in_data.x_value),
    .y_in    (in_data.y_value),
    .done    (cordic_done),
    .heading (cordic_heading)
  );

  always_comb begin
    x_low_next  = x_low;
    x_high_next = x_high;
    y_low_next  = y_low;
    y_high_next = y_high;
    z_low_next  = z_low;
    z_high_next = z_high;
    quiet_next  = quiet_count;
    done_next   = done_flag;
    finished    = 1'b0;
    widened     = 1'b0;
    unique case (in_data.mode)
      MODE_SAMPLE: begin
        if (!done_flag) begin
          if (in_data.x_value < x_low)  begin x_low_next  = in_data.x_value; widened = 1'b1; end
          if (in_data.x_value > x_high) begin x_high_next = in_data.x_value; widened = 1'b1; end
          if (in_data.y_value < y_low)  begin y_low_next  = in_data.y_value; widened = 1'b1; end
          if (in_data.y_value > y_high) begin y_high_next = in_data.y_value; widened = 1'b1; end
          if (in_data.z_value < z_low)  begin z_low_next  = in_data.z_value; widened = 1'b1; end
          if (in_data.z_value > z_high) begin z_high_next = in_data.z_value; widened = 1'b1; end
          if (widened) begin
            quiet_next = '0;
          end
          if (quiet_next > settle_ms) begin
            done_next = 1'b1;
            finished  = 1'b1;
          end
        end
      end
      MODE_TICK: begin
        if (quiet_count != QUIET_MAX) begin
          quiet_next = quiet_count + 1'b1;
        end
      end
      MODE_RESTART: begin
        x_low_next  = '0;
        x_high_next = '0;
        y_low_next  = '0;
        y_high_next = '0;
        z_low_next  = '0;
        z_high_next = '0;
        quiet_next  = '0;
        done_next   = 1'b0;
      end
      default: ;
    endcase

    item_result.calibrated    = done_next;
    item_result.finished_now  = finished;
    item_result.heading_valid = 1'b0;
    item_result.heading_deg   = '0;
    item_result.x_low         = x_low_next;
    item_result.x_high        = x_high_next;
    item_result.y_low         = y_low_next;
    item_result.y_high        = y_high_next;
    item_result.z_low         = z_low_next;
    item_result.z_high        = z_high_next;

    heading_result.calibrated    = done_flag;
    heading_result.finished_now  = 1'b0;
    heading_result.heading_valid = 1'b1;
    heading_result.heading_deg   = cordic_heading;
    heading_result.x_low         = x_low;
    heading_result.x_high        = x_high;
    heading_result.y_low         = y_low;
    heading_result.y_high        = y_high;
    heading_result.z_low         = z_low;
    heading_result.z_high        = z_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      settle_ms   <= SETTLE_RESET;
      quiet_count <= '0;
      done_flag   <= 1'b0;
      x_low       <= '0;
      x_high      <= '0;
      y_low       <= '0;
      y_high      <= '0;
      z_low       <= '0;
      z_high      <= '0;
    end else begin
      if (cfg_we) begin
        settle_ms <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (heading_item) begin
              state <= ST_BUSY;
            end else begin
              x_low       <= x_low_next;
              x_high      <= x_high_next;
              y_low       <= y_low_next;
              y_high      <= y_high_next;
              z_low       <= z_low_next;
              z_high      <= z_high_next;
              quiet_count <= quiet_next;
              done_flag   <= done_next;
            end
          end
        end
        ST_BUSY: begin
          if (cordic_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && accept && !heading_item) begin
      out_data <= item_result;
    end else if ((state == ST_FINISH) && slot_free) begin
      out_data <= heading_result;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mcal_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcal_checker
// Port-level checks on the magnetometer calibration and heading unit.
// ----------------------------------------------------------------------------
module mcal_checker import mcal_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input out_t                    out_data
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_heading_needs_cal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.heading_valid |-> out_data.calibrated && !out_data.finished_now)
    else $error("heading reported while not calibrated");

  a_finish_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.finished_now |-> out_data.calibrated)
    else $error("finish pulse without calibrated");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.heading_valid |-> out_data.heading_deg <= 9'd359)
    else $error("heading out of range");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.x_low <= out_data.x_high) && (out_data.y_low <= out_data.y_high)
                  && (out_data.z_low <= out_data.z_high))
    else $error("low bound above high bound");

endmodule

bind magnetometer_calibration_and_heading_unit mcal_checker u_mcal_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
